### src/matrix_point_transform_top_macros.svh
// Assertion macros shared by the checker of the matrix point transform.
// Needs nothing else; the including file supplies clock and reset names.
`ifndef MATRIX_POINT_TRANSFORM_TOP_MACROS_SVH
`define MATRIX_POINT_TRANSFORM_TOP_MACROS_SVH
`define MPT_ASSERT_NOW(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("matrix point transform check failed");
`define MPT_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("matrix point transform check failed");
`endif

### src/mpt_pkg.sv
// Shared widths, command codes and the result type of the point transform.
// Depends on nothing.
`timescale 1ns / 1ps
package mpt_pkg;
  localparam int ENTRY_W   = 32;
  localparam int VAL_W     = ENTRY_W + 1;
  localparam int ACC_W     = ENTRY_W + VAL_W + 2;
  localparam int OUT_W     = 32;
  localparam int NUM_REGS  = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 64;
  localparam int CMD_W     = 3;

  typedef logic [CMD_W-1:0] cmd_t;

  localparam cmd_t CMD_AFFINE    = 3'd0;
  localparam cmd_t CMD_ROTATE    = 3'd1;
  localparam cmd_t CMD_INV_RIGID = 3'd2;
  localparam cmd_t CMD_TRANS_ROT = 3'd3;
  localparam cmd_t CMD_PROJECT   = 3'd4;

  typedef struct packed {
    logic [OUT_W-1:0] x;
    logic [OUT_W-1:0] y;
    logic [OUT_W-1:0] z;
    logic             saturated;
    logic             w_zero;
  } result_t;
endpackage

### src/mpt_dot.sv
// Three-stage dot product of three terms plus a bias, shifted to fixed point.
// Depends on mpt_pkg.
`timescale 1ns / 1ps
module mpt_dot #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                    clk,
  input  logic                                    en,
  input  logic signed [mpt_pkg::ENTRY_W-1:0]      coef [3],
  input  logic signed [mpt_pkg::VAL_W-1:0]        val [3],
  input  logic signed [mpt_pkg::ENTRY_W-1:0]      bias,
  input  logic                                    bias_en,
  output logic signed [mpt_pkg::ACC_W-FRAC_BITS-1:0] sum_r
);
  localparam int PROD_W = mpt_pkg::ENTRY_W + mpt_pkg::VAL_W;
  localparam int ACC_W  = mpt_pkg::ACC_W;
  localparam int SUM_W  = ACC_W - FRAC_BITS;

  logic signed [PROD_W-1:0] prod_r [3];
  logic signed [ACC_W-1:0]  bias_r;
  logic signed [ACC_W-1:0]  s01_r;
  logic signed [ACC_W-1:0]  s2b_r;
  logic signed [ACC_W-1:0]  total;

  assign total = s01_r + s2b_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        prod_r[i] <= PROD_W'(coef[i]) * PROD_W'(val[i]);
      end
      bias_r <= bias_en ? (ACC_W'(bias) <<< FRAC_BITS) : '0;
      s01_r  <= ACC_W'(prod_r[0]) + ACC_W'(prod_r[1]);
      s2b_r  <= ACC_W'(prod_r[2]) + bias_r;
      sum_r  <= SUM_W'(total >>> FRAC_BITS);
    end
  end
endmodule

### src/mpt_div.sv
// Pipelined signed restoring divider, one quotient bit a stage, with saturation.
// Also saturates the undivided value for the non-projective commands. Depends on mpt_pkg.
`timescale 1ns / 1ps
module mpt_div #(
  parameter int FRAC_BITS   = 16,
  parameter int COORD_WIDTH = 32
) (
  input  logic                                       clk,
  input  logic                                       en,
  input  logic                                       proj,
  input  logic signed [mpt_pkg::ACC_W-FRAC_BITS-1:0] num,
  input  logic signed [mpt_pkg::ACC_W-FRAC_BITS-1:0] den,
  output logic signed [mpt_pkg::OUT_W-1:0]           res_r,
  output logic                                       sat_r
);
  localparam int CW    = COORD_WIDTH;
  localparam int SUM_W = mpt_pkg::ACC_W - FRAC_BITS;
  localparam int MAG_W = SUM_W;
  localparam int REM_W = SUM_W + 1;
  localparam int CMP_W = mpt_pkg::ACC_W + CW;
  localparam logic signed [SUM_W-1:0] SAT_HI =
    SUM_W'((longint'(1) <<< (CW - 1)) - longint'(1));
  localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);
  localparam logic [CW-1:0] HI_C = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] LO_C = {1'b1, {(CW-1){1'b0}}};

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [CW-1:0]    lo;
    logic [CW-1:0]    q;
    logic [MAG_W-1:0] d;
    logic             neg;
    logic             ovf;
    logic             proj;
    logic [CW-1:0]    nv;
    logic             nf;
  } step_t;

  logic             a_neg_r, a_proj_r, a_nf_r;
  logic [MAG_W-1:0] a_na_r, a_da_r;
  logic [CW-1:0]    a_nv_r;
  logic [CW-1:0]    nv;
  logic             nf;
  logic [CMP_W-1:0] dvd_x, dvs_x;
  step_t            st_r [CW+1];
  step_t            fin;
  logic [CW-1:0]    pres;
  logic             pflag;

  always_comb begin
    if (num > SAT_HI) begin
      nv = HI_C;
      nf = 1'b1;
    end else if (num < SAT_LO) begin
      nv = LO_C;
      nf = 1'b1;
    end else begin
      nv = num[CW-1:0];
      nf = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_neg_r  <= num[SUM_W-1] ^ den[SUM_W-1];
      a_na_r   <= num[SUM_W-1] ? MAG_W'(-num) : MAG_W'(num);
      a_da_r   <= den[SUM_W-1] ? MAG_W'(-den) : MAG_W'(den);
      a_proj_r <= proj;
      a_nv_r   <= nv;
      a_nf_r   <= nf;
    end
  end

  assign dvd_x = CMP_W'({a_na_r, {FRAC_BITS{1'b0}}});
  assign dvs_x = CMP_W'(a_da_r) << CW;

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0].rem  <= REM_W'(dvd_x >> CW);
      st_r[0].lo   <= dvd_x[CW-1:0];
      st_r[0].q    <= '0;
      st_r[0].d    <= a_da_r;
      st_r[0].neg  <= a_neg_r;
      st_r[0].ovf  <= dvd_x >= dvs_x;
      st_r[0].proj <= a_proj_r;
      st_r[0].nv   <= a_nv_r;
      st_r[0].nf   <= a_nf_r;
    end
  end

  for (genvar k = 0; k < CW; k++) begin : g_step
    logic [REM_W-1:0] trial;
    logic             ge;
    step_t            nxt;

    assign trial = {st_r[k].rem[REM_W-2:0], st_r[k].lo[CW-1]};
    assign ge    = trial >= {1'b0, st_r[k].d};

    always_comb begin
      nxt     = st_r[k];
      nxt.rem = ge ? trial - {1'b0, st_r[k].d} : trial;
      nxt.lo  = {st_r[k].lo[CW-2:0], 1'b0};
      nxt.q   = {st_r[k].q[CW-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[k+1] <= nxt;
      end
    end
  end

  assign fin = st_r[CW];

  always_comb begin
    if (fin.ovf) begin
      pres  = fin.neg ? LO_C : HI_C;
      pflag = 1'b1;
    end else if (fin.neg) begin
      pres  = (fin.q > LO_C) ? LO_C : -fin.q;
      pflag = fin.q > LO_C;
    end else begin
      pres  = (fin.q > HI_C) ? HI_C : fin.q;
      pflag = fin.q > HI_C;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= fin.proj ? mpt_pkg::OUT_W'($signed(pres)) : mpt_pkg::OUT_W'($signed(fin.nv));
      sat_r <= fin.proj ? pflag : fin.nf;
    end
  end
endmodule

### src/mpt_outq.sv
// Two-entry output queue that lets the pipeline run while a result waits.
// Depends on mpt_pkg.
`timescale 1ns / 1ps
module mpt_outq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  mpt_pkg::result_t din,
  input  logic             out_stall,
  output logic             out_valid,
  output mpt_pkg::result_t dout,
  output logic             full
);
  mpt_pkg::result_t mem [2];
  logic             wr_ptr_r, rd_ptr_r;
  logic [1:0]       count_r;
  logic             pop;

  assign out_valid = count_r != 2'd0;
  assign pop       = out_valid && !out_stall;
  assign full      = count_r == 2'd2;
  assign dout      = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (!push && pop) begin
        count_r <= count_r - 2'd1;
      end
    end
  end
endmodule

### src/matrix_point_transform_top.sv
// Top level of the 4x4 matrix point transform: configuration, pipeline control.
// Depends on mpt_pkg, mpt_dot, mpt_div and mpt_outq.
//
// Usage: a point (in_cmd, in_x, in_y, in_z) is taken on a transaction of the
// input channel (in_valid high, in_stall low). Its transformed point, with the
// saturated and w_zero flags, leaves on a transaction of the output channel.
// The matrix is written through cfg_we, cfg_index and cfg_wdata; it resets
// to identity. The user must write it only while no point is in flight; the
// block does not enforce this. Throughput is one point per cycle while
// in_stall is low. The pipeline depth is set by the divider, which resolves
// one quotient bit per stage.
// A synchronous active-low reset empties the pipeline and output queue.
// When the receiver stalls, the result is held; the two-entry output queue
// lets one more result complete before in_stall is raised and the whole
// pipeline holds.
`timescale 1ns / 1ps
module matrix_point_transform_top #(
  parameter int FRAC_BITS   = 16,
  parameter int COORD_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [mpt_pkg::CMD_W-1:0]           in_cmd,
  input  logic signed [31:0]                  in_x,
  input  logic signed [31:0]                  in_y,
  input  logic signed [31:0]                  in_z,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [mpt_pkg::OUT_W-1:0]    out_x,
  output logic signed [mpt_pkg::OUT_W-1:0]    out_y,
  output logic signed [mpt_pkg::OUT_W-1:0]    out_z,
  output logic                                out_saturated,
  output logic                                out_w_zero,
  input  logic                                cfg_we,
  input  logic [mpt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mpt_pkg::CFG_W-1:0]           cfg_wdata
);
  localparam int EW       = mpt_pkg::ENTRY_W;
  localparam int VW       = mpt_pkg::VAL_W;
  localparam int SUM_W    = mpt_pkg::ACC_W - FRAC_BITS;
  localparam int DEPTH    = COORD_WIDTH + 7;
  localparam int WZ_STAGE = 4;
  localparam logic [mpt_pkg::CFG_W-1:0] ONE = mpt_pkg::CFG_W'(1) << FRAC_BITS;

  typedef struct packed {
    logic valid;
    logic ok;
    logic proj;
    logic wz;
  } ctl_t;

  logic [mpt_pkg::CFG_W-1:0] cfg_r [mpt_pkg::NUM_REGS];
  logic signed [EW-1:0]      ent [4][4];
  logic                      en, accept, full;
  logic                      trans, sub, bias_on, cmd_ok, proj;
  logic signed [VW-1:0]      p [3];
  logic signed [EW-1:0]      coef_nxt [3][3];
  logic signed [VW-1:0]      val_nxt [3];
  logic signed [EW-1:0]      s1_coef_r [3][3];
  logic signed [VW-1:0]      s1_val_r [3];
  logic signed [EW-1:0]      s1_bias_r [3];
  logic                      s1_bias_en_r;
  logic signed [EW-1:0]      s1_wcoef_r [3];
  logic signed [VW-1:0]      s1_p_r [3];
  logic signed [EW-1:0]      s1_wbias_r;
  logic signed [SUM_W-1:0]   sum [3];
  logic signed [SUM_W-1:0]   wsum;
  logic signed [mpt_pkg::OUT_W-1:0] res [3];
  logic                      sat [3];
  ctl_t                      ctl_r [DEPTH];
  ctl_t                      last;
  logic                      pass;
  mpt_pkg::result_t          item, dout;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r[0] <= ONE;
      cfg_r[1] <= '0;
      cfg_r[2] <= ONE << 32;
      cfg_r[3] <= '0;
      cfg_r[4] <= '0;
      cfg_r[5] <= ONE;
      cfg_r[6] <= '0;
      cfg_r[7] <= ONE << 32;
    end else if (cfg_we) begin
      cfg_r[cfg_index] <= cfg_wdata;
    end
  end

  for (genvar r = 0; r < 4; r++) begin : g_ent_row
    for (genvar c = 0; c < 4; c++) begin : g_ent_col
      assign ent[r][c] = cfg_r[2*r + c/2][(c%2)*32 +: 32];
    end
  end

  assign en       = !full;
  assign in_stall = full;
  assign accept   = in_valid && !in_stall;

  assign trans   = in_cmd == mpt_pkg::CMD_INV_RIGID || in_cmd == mpt_pkg::CMD_TRANS_ROT;
  assign sub     = in_cmd == mpt_pkg::CMD_INV_RIGID;
  assign bias_on = in_cmd == mpt_pkg::CMD_AFFINE || in_cmd == mpt_pkg::CMD_PROJECT;
  assign proj    = in_cmd == mpt_pkg::CMD_PROJECT;
  assign cmd_ok  = in_cmd == mpt_pkg::CMD_AFFINE || in_cmd == mpt_pkg::CMD_ROTATE ||
                   in_cmd == mpt_pkg::CMD_INV_RIGID || in_cmd == mpt_pkg::CMD_TRANS_ROT ||
                   in_cmd == mpt_pkg::CMD_PROJECT;

  assign p[0] = VW'($signed(in_x[COORD_WIDTH-1:0]));
  assign p[1] = VW'($signed(in_y[COORD_WIDTH-1:0]));
  assign p[2] = VW'($signed(in_z[COORD_WIDTH-1:0]));

  for (genvar r = 0; r < 3; r++) begin : g_sel_row
    assign val_nxt[r] = sub ? p[r] - VW'(ent[r][3]) : p[r];
    for (genvar c = 0; c < 3; c++) begin : g_sel_col
      assign coef_nxt[r][c] = trans ? ent[c][r] : ent[r][c];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        s1_val_r[r]   <= val_nxt[r];
        s1_bias_r[r]  <= ent[r][3];
        s1_wcoef_r[r] <= ent[3][r];
        s1_p_r[r]     <= p[r];
        for (int c = 0; c < 3; c++) begin
          s1_coef_r[r][c] <= coef_nxt[r][c];
        end
      end
      s1_bias_en_r <= bias_on;
      s1_wbias_r   <= ent[3][3];
    end
  end

  for (genvar r = 0; r < 3; r++) begin : g_row
    mpt_dot #(.FRAC_BITS(FRAC_BITS)) u_dot (
      .clk    (clk),
      .en     (en),
      .coef   (s1_coef_r[r]),
      .val    (s1_val_r),
      .bias   (s1_bias_r[r]),
      .bias_en(s1_bias_en_r),
      .sum_r  (sum[r])
    );

    mpt_div #(.FRAC_BITS(FRAC_BITS), .COORD_WIDTH(COORD_WIDTH)) u_div (
      .clk  (clk),
      .en   (en),
      .proj (ctl_r[WZ_STAGE-1].proj),
      .num  (sum[r]),
      .den  (wsum),
      .res_r(res[r]),
      .sat_r(sat[r])
    );
  end

  mpt_dot #(.FRAC_BITS(FRAC_BITS)) u_dot_w (
    .clk    (clk),
    .en     (en),
    .coef   (s1_wcoef_r),
    .val    (s1_p_r),
    .bias   (s1_wbias_r),
    .bias_en(1'b1),
    .sum_r  (wsum)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DEPTH; k++) begin
        ctl_r[k] <= '0;
      end
    end else if (en) begin
      ctl_r[0] <= '{valid: accept, ok: cmd_ok, proj: proj, wz: 1'b0};
      for (int k = 1; k < DEPTH; k++) begin
        if (k == WZ_STAGE) begin
          ctl_r[k] <= '{valid: ctl_r[k-1].valid, ok: ctl_r[k-1].ok,
                        proj: ctl_r[k-1].proj, wz: wsum == '0};
        end else begin
          ctl_r[k] <= ctl_r[k-1];
        end
      end
    end
  end

  assign last = ctl_r[DEPTH-1];
  assign pass = last.ok && !(last.proj && last.wz);

  always_comb begin
    item.x         = pass ? res[0] : '0;
    item.y         = pass ? res[1] : '0;
    item.z         = pass ? res[2] : '0;
    item.saturated = pass && (sat[0] || sat[1] || sat[2]);
    item.w_zero    = last.ok && last.proj && last.wz;
  end

  mpt_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (en && last.valid),
    .din      (item),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .dout     (dout),
    .full     (full)
  );

  assign out_x         = dout.x;
  assign out_y         = dout.y;
  assign out_z         = dout.z;
  assign out_saturated = dout.saturated;
  assign out_w_zero    = dout.w_zero;
endmodule

### src/mpt_chk.sv
// Port-level checker for the matrix point transform, bound to the top level.
// Depends on matrix_point_transform_top_macros.svh.
`timescale 1ns / 1ps
`include "matrix_point_transform_top_macros.svh"
module mpt_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_x,
  input logic [31:0] out_y,
  input logic [31:0] out_z,
  input logic        out_saturated,
  input logic        out_w_zero
);
  `MPT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
  `MPT_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_x) && $stable(out_y) && $stable(out_z))
  `MPT_ASSERT_NOW(a_wzero_clear, clk, rst_n, out_valid && out_w_zero, out_x == 0 && out_y == 0 && out_z == 0 && !out_saturated)
  `MPT_ASSERT_NOW(a_stall_cause, clk, rst_n, in_stall, $past(out_valid && out_stall))
endmodule

bind matrix_point_transform_top mpt_chk u_mpt_chk (.*);
